[rtl/core/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants and types for the bucketed histogram statistics core.
// ----------------------------------------------------------------------------
package hbs_pkg;

   localparam int NUM_BOUNDARIES = 7;
   localparam int NUM_BUCKETS    = NUM_BOUNDARIES + 1;
   localparam int SAMPLE_WIDTH   = 32;
   localparam int COUNT_WIDTH    = 32;
   localparam int SUM_WIDTH      = 64;
   localparam int BIDX_WIDTH     = 3;
   localparam int NB_WIDTH       = 3;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int DIV_STEPS      = SUM_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOUNDARIES_IN_USE = '0;

   localparam logic [NB_WIDTH-1:0] NB_RESET = NB_WIDTH'(NUM_BOUNDARIES);

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SUM_WIDTH-1:0]    SUM_MAX    = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0]    SUM_MIN    = {1'b1, {(SUM_WIDTH-1){1'b0}}};
   localparam logic [COUNT_WIDTH-1:0]         COUNT_MAX  = '1;

   // Quotient limits for the mean, as unsigned magnitudes.
   localparam logic [SUM_WIDTH-1:0] MEAN_POS_LIMIT =
      {{(SUM_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] MEAN_NEG_LIMIT = MEAN_POS_LIMIT + SUM_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [SUM_WIDTH-1:0]  dividend;
      logic [COUNT_WIDTH-1:0] divisor;
   } div_req_type;

endpackage

[rtl/core/hbs_divider.sv]
// ----------------------------------------------------------------------------
// hbs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbs_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  hbs_pkg::div_req_type               div_req,
   output logic                               done,
   output logic [hbs_pkg::SUM_WIDTH-1:0]      quotient
);

   logic                                  run_ff, run_in;
   logic                                  done_ff, done_in;
   logic [hbs_pkg::DIV_CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [hbs_pkg::COUNT_WIDTH-1:0]       rem_ff, rem_in;
   logic [hbs_pkg::SUM_WIDTH-1:0]         quo_ff, quo_in;
   logic [hbs_pkg::COUNT_WIDTH-1:0]       div_ff, div_in;
   logic [hbs_pkg::COUNT_WIDTH:0]         trial;
   logic [hbs_pkg::COUNT_WIDTH:0]         diff;
   logic                                  fits;

   // The dividend shifts out of the top of the quotient register while the
   // quotient bits shift in at the bottom.
   assign trial = {rem_ff, quo_ff[hbs_pkg::SUM_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         div_in = div_req.divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[hbs_pkg::COUNT_WIDTH-1:0] : trial[hbs_pkg::COUNT_WIDTH-1:0];
         quo_in = {quo_ff[hbs_pkg::SUM_WIDTH-2:0], fits};
         cnt_in = cnt_ff + hbs_pkg::DIV_CNT_WIDTH'(1);
         if (cnt_ff == hbs_pkg::DIV_CNT_WIDTH'(hbs_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/bucketed_histogram_stats_core.sv]
// ----------------------------------------------------------------------------
// bucketed_histogram_stats_core
// Histogram over signed Q16.16 samples with running min, max, count, sum
// and mean, driven by a small sequencer around one shared divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid/req_ready    req_type, req_sample, req_query_bucket
//  rsp_      out        rsp_valid/rsp_ready    bucket, min, max, total, sum, mean, empty
//  csr_      in         csr_we                 csr_index, csr_wdata
//
// An add request scans the N active boundaries (one per cycle on a single
// comparator), updates the statistics, then runs the bit-serial mean divider;
// a read only runs the divider, a clear empties the statistics first. One
// request is in progress at a time; a finished response waits in the output
// register, and the next request is accepted while it waits. Reset is
// synchronous and clears statistics, configuration, state and valid flags.
module bucketed_histogram_stats_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_type,
   input  logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]   req_sample,
   input  logic [hbs_pkg::BIDX_WIDTH-1:0]            req_query_bucket,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [hbs_pkg::BIDX_WIDTH-1:0]            rsp_bucket_index,
   output logic [hbs_pkg::COUNT_WIDTH-1:0]           rsp_bucket_count,
   output logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]   rsp_min_value,
   output logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]   rsp_max_value,
   output logic [hbs_pkg::COUNT_WIDTH-1:0]           rsp_sample_total,
   output logic signed [hbs_pkg::SUM_WIDTH-1:0]      rsp_sample_sum,
   output logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]   rsp_mean_value,
   output logic                                      rsp_is_empty,
   input  logic                                      csr_we,
   input  logic [hbs_pkg::CSR_IDX_WIDTH-1:0]         csr_index,
   input  logic [hbs_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   hbs_pkg::state_type state_ff, state_in;

   // Configuration.
   logic [hbs_pkg::NB_WIDTH-1:0]                  nb_ff;
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       boundary_ff [hbs_pkg::NUM_BOUNDARIES];

   // Statistics.
   logic [hbs_pkg::COUNT_WIDTH-1:0]               bucket_ff [hbs_pkg::NUM_BUCKETS];
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       min_ff;
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       max_ff;
   logic [hbs_pkg::COUNT_WIDTH-1:0]               count_ff;
   logic signed [hbs_pkg::SUM_WIDTH-1:0]          sum_ff;

   // Request in progress.
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       sample_ff;
   logic [hbs_pkg::BIDX_WIDTH-1:0]                idx_ff;
   logic [hbs_pkg::NB_WIDTH-1:0]                  scan_ff;
   logic                                          neg_ff;

   // Response register.
   logic                                          rsp_valid_ff;
   logic [hbs_pkg::BIDX_WIDTH-1:0]                rsp_idx_ff;
   logic [hbs_pkg::COUNT_WIDTH-1:0]               rsp_bcount_ff;
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       rsp_min_ff;
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       rsp_max_ff;
   logic [hbs_pkg::COUNT_WIDTH-1:0]               rsp_total_ff;
   logic signed [hbs_pkg::SUM_WIDTH-1:0]          rsp_sum_ff;
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       rsp_mean_ff;
   logic                                          rsp_empty_ff;

   logic                                          req_fire;
   logic                                          slot_free;
   logic [hbs_pkg::NB_WIDTH-1:0]                  nb_active;
   logic                                          scan_last;
   logic                                          scan_hit;
   logic signed [hbs_pkg::SUM_WIDTH-1:0]          sample_ext;
   logic signed [hbs_pkg::SUM_WIDTH-1:0]          sum_add;
   logic                                          sum_ovf;
   logic [hbs_pkg::SUM_WIDTH-1:0]                 sum_mag;
   logic signed [hbs_pkg::SAMPLE_WIDTH-1:0]       mean;
   logic                                          div_start;
   hbs_pkg::div_req_type                          div_req;
   logic                                          div_done;
   logic [hbs_pkg::SUM_WIDTH-1:0]                 quotient;

   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // A count of zero active boundaries behaves as one.
   assign nb_active = (nb_ff == '0) ? hbs_pkg::NB_WIDTH'(1) : nb_ff;
   assign scan_last = (scan_ff == nb_active - hbs_pkg::NB_WIDTH'(1));
   assign scan_hit  = boundary_ff[scan_ff] <= sample_ff;

   assign sample_ext = hbs_pkg::SUM_WIDTH'(sample_ff);
   assign sum_add    = sum_ff + sample_ext;
   assign sum_ovf    = (sum_ff[hbs_pkg::SUM_WIDTH-1] == sample_ext[hbs_pkg::SUM_WIDTH-1]) &&
                       (sum_add[hbs_pkg::SUM_WIDTH-1] != sum_ff[hbs_pkg::SUM_WIDTH-1]);
   assign sum_mag    = sum_ff[hbs_pkg::SUM_WIDTH-1] ? -sum_ff : sum_ff;

   assign div_req.start    = div_start;
   assign div_req.dividend = sum_mag;
   assign div_req.divisor  = count_ff;

   hbs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   // Truncated mean, clamped to the sample range.
   always_comb begin
      if (count_ff == '0) begin
         mean = '0;
      end else if (neg_ff) begin
         if (quotient > hbs_pkg::MEAN_NEG_LIMIT) begin
            mean = hbs_pkg::SAMPLE_MIN;
         end else begin
            mean = -quotient[hbs_pkg::SAMPLE_WIDTH-1:0];
         end
      end else begin
         if (quotient > hbs_pkg::MEAN_POS_LIMIT) begin
            mean = hbs_pkg::SAMPLE_MAX;
         end else begin
            mean = quotient[hbs_pkg::SAMPLE_WIDTH-1:0];
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbs_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_type == hbs_pkg::REQ_ADD) ? hbs_pkg::ST_SCAN
                                                         : hbs_pkg::ST_DIV_START;
            end
         end
         hbs_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = hbs_pkg::ST_UPDATE;
            end
         end
         hbs_pkg::ST_UPDATE:    state_in = hbs_pkg::ST_DIV_START;
         hbs_pkg::ST_DIV_START: state_in = hbs_pkg::ST_DIV_WAIT;
         hbs_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = hbs_pkg::ST_DONE;
            end
         end
         hbs_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = hbs_pkg::ST_IDLE;
            end
         end
         default: state_in = hbs_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         hbs_pkg::ST_IDLE:      req_ready = 1'b1;
         hbs_pkg::ST_DIV_START: div_start = 1'b1;
         default: begin
            req_ready = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff <= hbs_pkg::NB_RESET;
         for (int i = 0; i < hbs_pkg::NUM_BOUNDARIES; i++) begin
            boundary_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == hbs_pkg::CSR_BOUNDARIES_IN_USE) begin
            nb_ff <= csr_wdata[hbs_pkg::NB_WIDTH-1:0];
         end else begin
            boundary_ff[csr_index - hbs_pkg::CSR_IDX_WIDTH'(1)] <=
               csr_wdata[hbs_pkg::SAMPLE_WIDTH-1:0];
         end
      end
   end

   // Statistics and the request in progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hbs_pkg::NUM_BUCKETS; i++) begin
            bucket_ff[i] <= '0;
         end
         min_ff   <= hbs_pkg::SAMPLE_MAX;
         max_ff   <= hbs_pkg::SAMPLE_MIN;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         unique case (state_ff)
            hbs_pkg::ST_IDLE: begin
               if (req_fire && req_type == hbs_pkg::REQ_CLEAR) begin
                  for (int i = 0; i < hbs_pkg::NUM_BUCKETS; i++) begin
                     bucket_ff[i] <= '0;
                  end
                  min_ff   <= hbs_pkg::SAMPLE_MAX;
                  max_ff   <= hbs_pkg::SAMPLE_MIN;
                  count_ff <= '0;
                  sum_ff   <= '0;
               end
            end
            hbs_pkg::ST_UPDATE: begin
               if (bucket_ff[idx_ff] != hbs_pkg::COUNT_MAX) begin
                  bucket_ff[idx_ff] <= bucket_ff[idx_ff] + hbs_pkg::COUNT_WIDTH'(1);
               end
               if (sample_ff < min_ff) begin
                  min_ff <= sample_ff;
               end
               if (sample_ff > max_ff) begin
                  max_ff <= sample_ff;
               end
               if (count_ff != hbs_pkg::COUNT_MAX) begin
                  count_ff <= count_ff + hbs_pkg::COUNT_WIDTH'(1);
               end
               if (sum_ovf) begin
                  sum_ff <= sum_ff[hbs_pkg::SUM_WIDTH-1] ? hbs_pkg::SUM_MIN : hbs_pkg::SUM_MAX;
               end else begin
                  sum_ff <= sum_add;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_sample;
         idx_ff    <= (req_type == hbs_pkg::REQ_ADD) ? '0 : req_query_bucket;
         scan_ff   <= '0;
      end else if (state_ff == hbs_pkg::ST_SCAN) begin
         if (scan_hit) begin
            idx_ff <= idx_ff + hbs_pkg::BIDX_WIDTH'(1);
         end
         scan_ff <= scan_ff + hbs_pkg::NB_WIDTH'(1);
      end
      if (state_ff == hbs_pkg::ST_DIV_START) begin
         neg_ff <= sum_ff[hbs_pkg::SUM_WIDTH-1];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == hbs_pkg::ST_DONE && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == hbs_pkg::ST_DONE && slot_free) begin
         rsp_idx_ff    <= idx_ff;
         rsp_bcount_ff <= bucket_ff[idx_ff];
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_total_ff  <= count_ff;
         rsp_sum_ff    <= sum_ff;
         rsp_mean_ff   <= mean;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_idx_ff;
   assign rsp_bucket_count = rsp_bcount_ff;
   assign rsp_min_value    = rsp_min_ff;
   assign rsp_max_value    = rsp_max_ff;
   assign rsp_sample_total = rsp_total_ff;
   assign rsp_sample_sum   = rsp_sum_ff;
   assign rsp_mean_value   = rsp_mean_ff;
   assign rsp_is_empty     = rsp_empty_ff;

   // An empty histogram holds the cleared sum and extremes.
   a_empty_cleared: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0 && min_ff == hbs_pkg::SAMPLE_MAX &&
                            max_ff == hbs_pkg::SAMPLE_MIN))
      else $error("empty statistics not in cleared state");

   // Once a sample is in, the minimum never exceeds the maximum.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum above maximum");

   // An update always leaves at least one sample counted.
   a_update_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbs_pkg::ST_UPDATE) |=> (count_ff != '0))
      else $error("sample count zero after update");

   // The divider reports completion only while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == hbs_pkg::ST_DIV_WAIT))
      else $error("divider finished outside its wait state");

endmodule
